[src/sector_field_accumulator_assert.svh]
// ---------------------------------------------------------------------------
// Sector field accumulator assertion macros
// Shorthand for the concurrent checks on the accumulator's ports.
// ---------------------------------------------------------------------------
`ifndef SECTOR_FIELD_ACCUMULATOR_ASSERT_SVH
`define SECTOR_FIELD_ACCUMULATOR_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define SFA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define SFA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/sfa_pkg.sv]
// ---------------------------------------------------------------------------
// Sector field accumulator package
// Shared widths, codes, configuration type and arithmetic helpers.
// ---------------------------------------------------------------------------
package sfa_pkg;

	// Default sizing
	localparam int NUM_SECTORS_DEF = 8;
	localparam int ACC_WIDTH_DEF   = 40;

	// Field widths
	localparam int MODE_W      = 2;
	localparam int ANGLE_W     = 16;
	localparam int VAL_W       = 16;
	localparam int GSEC_W      = 3;
	localparam int SIDX_W      = 3;
	localparam int SUM_W       = 40;
	localparam int IN_TDATA_W  = 56;
	localparam int IN_TUSER_W  = MODE_W;
	localparam int OUT_TDATA_W = 2 * SUM_W;
	localparam int OUT_TUSER_W = SIDX_W;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int COUNT_W    = 4;

	// Arithmetic
	localparam int PROD_W  = 2 * VAL_W;
	localparam int CSUM_W  = PROD_W + 1;
	localparam int ROOT_W  = VAL_W + 1;
	localparam logic signed [VAL_W-1:0] GAIN_UNITY = 16'sd16384;

	// Queue: kind, sector, real, imaginary
	localparam int KIND_W      = 2;
	localparam int CMD_FIXED_W = KIND_W + 2 * VAL_W;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [MODE_W-1:0] {
		MODE_RAY  = 2'd0,
		MODE_GAIN = 2'd1,
		MODE_READ = 2'd2
	} mode_t;

	typedef enum logic [KIND_W-1:0] {
		CMD_RAY  = 2'd0,
		CMD_GAIN = 2'd1,
		CMD_READ = 2'd2
	} cmd_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SECTOR_COUNT = 2'd0,
		REG_SECTOR_WIDTH = 2'd1,
		REG_MAG_MODE     = 2'd2,
		REG_GAIN_EN      = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [COUNT_W-1:0] sector_count;
		logic [ANGLE_W-1:0] sector_width;
		logic               magnitude_mode;
		logic               gain_enable;
	} cfg_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_EVAL,
		F_SEARCH,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_RND,
		B_SQ,
		B_SQRT,
		B_ACC,
		B_RO_RD,
		B_RO_OUT
	} back_state_t;

	// Index width for a table of n entries
	function automatic int idx_w(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

	// Sector count clamped to the built table size
	function automatic int active_count(input logic [COUNT_W-1:0] cnt, input int n);
		return (int'(cnt) > n) ? n : int'(cnt);
	endfunction

	// Round a Q4.29 product sum to Q1.15 with saturation
	function automatic logic signed [VAL_W-1:0] round_q15(input logic signed [CSUM_W-1:0] x);
		logic signed [CSUM_W:0] t;
		logic signed [CSUM_W-14:0] sh;
		t  = (CSUM_W+1)'(x) + (CSUM_W+1)'(8192);
		sh = (CSUM_W-13)'(t >>> 14);
		if (sh > (CSUM_W-13)'(32767)) begin
			return 16'sh7fff;
		end else if (sh < -(CSUM_W-13)'(32768)) begin
			return 16'sh8000;
		end
		return sh[VAL_W-1:0];
	endfunction

endpackage

[src/sfa_ram.sv]
// ---------------------------------------------------------------------------
// Sector field accumulator RAM
// Generic one-write, one-read memory with a registered read port.
// ---------------------------------------------------------------------------
module sfa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                               clk,
	input  logic                               we,
	input  logic [sfa_pkg::idx_w(DEPTH)-1:0]   waddr,
	input  logic [WIDTH-1:0]                   wdata,
	input  logic [sfa_pkg::idx_w(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]                   rdata
);
	import sfa_pkg::*;

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[src/sfa_queue.sv]
// ---------------------------------------------------------------------------
// Sector field accumulator command queue
// Short FIFO that decouples the classifying front end from the back end.
// ---------------------------------------------------------------------------
module sfa_queue #(
	parameter int WIDTH = 37,
	parameter int DEPTH = sfa_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             pop_valid,
	output logic [WIDTH-1:0] pop_data
);
	import sfa_pkg::*;

	localparam int PTR_W = idx_w(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data  = entry_q[rd_ptr_q];

	// Store pushed commands
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

[src/sfa_front.sv]
// ---------------------------------------------------------------------------
// Sector field accumulator front end
// Accepts input items, finds the sector of each ray and queues commands.
// ---------------------------------------------------------------------------
module sfa_front #(
	parameter int NUM_SECTORS = sfa_pkg::NUM_SECTORS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  sfa_pkg::cfg_t                          cfg,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// s_tdata: departure_angle[15:0], value_re[31:16], value_im[47:32],
	//          gain_sector[50:48], zero pad[55:51]
	input  logic [sfa_pkg::IN_TDATA_W-1:0]         s_tdata,
	// s_tuser: mode[1:0]
	input  logic [sfa_pkg::IN_TUSER_W-1:0]         s_tuser,
	output logic                                   push,
	output logic [sfa_pkg::CMD_FIXED_W + sfa_pkg::idx_w(NUM_SECTORS)-1:0] push_data,
	input  logic                                   full
);
	import sfa_pkg::*;

	localparam int SEC_W  = idx_w(NUM_SECTORS);
	localparam int CNT_W  = $clog2(NUM_SECTORS + 1);
	localparam int EDGE_W = ANGLE_W + CNT_W;

	front_state_t             state_q, state_d;
	mode_t                    mode_q;
	logic [ANGLE_W-1:0]       angle_q;
	logic [VAL_W-1:0]         re_q;
	logic [VAL_W-1:0]         im_q;
	logic [GSEC_W-1:0]        gsec_q;
	logic [CNT_W-1:0]         k_q;
	logic [EDGE_W-1:0]        bound_q;

	logic                     accept;
	logic                     hit;
	logic                     gain_ok;
	logic                     srch_init;
	logic                     srch_step;
	logic [CNT_W-1:0]         n_act;
	cmd_kind_t                kind;
	logic [SEC_W-1:0]         sec;

	assign accept  = s_tvalid && s_tready;
	assign n_act   = CNT_W'(active_count(cfg.sector_count, NUM_SECTORS));
	assign hit     = (EDGE_W'(angle_q) <= bound_q);
	assign gain_ok = (int'(gsec_q) < NUM_SECTORS);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: begin
				if (accept) begin
					state_d = F_EVAL;
				end
			end
			F_EVAL: begin
				case (mode_q)
					MODE_RAY:  state_d = F_SEARCH;
					MODE_GAIN: state_d = gain_ok ? F_PUSH : F_IDLE;
					MODE_READ: state_d = F_PUSH;
					default:   state_d = F_IDLE;
				endcase
			end
			F_SEARCH: begin
				if (k_q == n_act) begin
					state_d = F_IDLE;
				end else if (hit) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				if (!full) begin
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		s_tready  = (state_q == F_IDLE);
		push      = (state_q == F_PUSH) && !full;
		srch_init = (state_q == F_EVAL) && (mode_q == MODE_RAY);
		srch_step = (state_q == F_SEARCH) && (k_q != n_act) && !hit;
	end

	// Build the queued command
	always_comb begin
		case (mode_q)
			MODE_GAIN: kind = CMD_GAIN;
			MODE_READ: kind = CMD_READ;
			default:   kind = CMD_RAY;
		endcase
		sec       = (mode_q == MODE_GAIN) ? SEC_W'(gsec_q) : SEC_W'(k_q);
		push_data = {im_q, re_q, sec, kind};
	end

	// Capture the accepted item
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= mode_t'(s_tuser);
			angle_q <= s_tdata[15:0];
			re_q    <= s_tdata[31:16];
			im_q    <= s_tdata[47:32];
			gsec_q  <= s_tdata[50:48];
		end
	end

	// Sequencer and sector search, one sector edge per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			k_q     <= '0;
			bound_q <= '0;
		end else begin
			state_q <= state_d;
			if (srch_init) begin
				k_q     <= '0;
				bound_q <= EDGE_W'(cfg.sector_width);
			end else if (srch_step) begin
				k_q     <= k_q + CNT_W'(1);
				bound_q <= bound_q + EDGE_W'(cfg.sector_width);
			end
		end
	end

endmodule

[src/sfa_back.sv]
// ---------------------------------------------------------------------------
// Sector field accumulator back end
// Executes queued commands: gain loads, ray accumulation and readout.
// ---------------------------------------------------------------------------
module sfa_back #(
	parameter int NUM_SECTORS = sfa_pkg::NUM_SECTORS_DEF,
	parameter int ACC_WIDTH   = sfa_pkg::ACC_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  sfa_pkg::cfg_t                          cfg,
	input  logic                                   q_valid,
	input  logic [sfa_pkg::CMD_FIXED_W + sfa_pkg::idx_w(NUM_SECTORS)-1:0] q_data,
	output logic                                   q_pop,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// m_tdata: sum_re[39:0], sum_im[79:40]
	output logic [sfa_pkg::OUT_TDATA_W-1:0]        m_tdata,
	// m_tuser: sector_index[2:0]
	output logic [sfa_pkg::OUT_TUSER_W-1:0]        m_tuser,
	output logic                                   m_tlast
);
	import sfa_pkg::*;

	localparam int SEC_W = idx_w(NUM_SECTORS);
	localparam int CNT_W = $clog2(NUM_SECTORS + 1);
	localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
	localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

	// Saturating accumulate
	function automatic logic signed [ACC_WIDTH-1:0] sat_add(
		input logic signed [ACC_WIDTH-1:0] a,
		input logic signed [ACC_WIDTH-1:0] b
	);
		logic signed [ACC_WIDTH:0] s;
		s = (ACC_WIDTH+1)'(a) + (ACC_WIDTH+1)'(b);
		if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
			return s[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
		end
		return s[ACC_WIDTH-1:0];
	endfunction

	back_state_t                  state_q, state_d;

	// Queue head
	cmd_kind_t                    q_kind;
	logic [SEC_W-1:0]             q_sec;
	logic [VAL_W-1:0]             q_re;
	logic [VAL_W-1:0]             q_im;

	// Working registers
	logic [SEC_W-1:0]             cur_sec_q;
	logic signed [VAL_W-1:0]      vr_q;
	logic signed [VAL_W-1:0]      vi_q;
	logic [2:0]                   step_q;
	logic signed [PROD_W-1:0]     prod_q;
	logic signed [CSUM_W-1:0]     re_acc_q;
	logic signed [CSUM_W-1:0]     im_acc_q;
	logic [PROD_W-1:0]            sq_q;
	logic [PROD_W-1:0]            rem_q;
	logic [PROD_W-1:0]            root_q;
	logic [PROD_W-1:0]            bit_q;
	logic [CNT_W-1:0]             k_q;
	logic [NUM_SECTORS-1:0]       acc_vld_q;
	logic [NUM_SECTORS-1:0]       gain_vld_q;

	// Output register
	logic                         out_vld_q;
	logic [SIDX_W-1:0]            out_idx_q;
	logic [SUM_W-1:0]             out_re_q;
	logic [SUM_W-1:0]             out_im_q;
	logic                         out_last_q;

	// Memories
	logic                         gain_we;
	logic [2*VAL_W-1:0]           gain_rd;
	logic                         acc_we;
	logic [2*ACC_WIDTH-1:0]       acc_wdata;
	logic [2*ACC_WIDTH-1:0]       acc_rd;
	logic [SEC_W-1:0]             rd_addr;

	// Datapath
	logic [CNT_W-1:0]             n_act;
	logic [SEC_W-1:0]             k_sec;
	logic signed [VAL_W-1:0]      gr;
	logic signed [VAL_W-1:0]      gi;
	logic signed [VAL_W-1:0]      mul_a;
	logic signed [VAL_W-1:0]      mul_b;
	logic [PROD_W-1:0]            trial;
	logic signed [ACC_WIDTH-1:0]  old_re;
	logic signed [ACC_WIDTH-1:0]  old_im;
	logic signed [ACC_WIDTH-1:0]  add_re;
	logic signed [ACC_WIDTH-1:0]  new_re;
	logic signed [ACC_WIDTH-1:0]  new_im;
	logic signed [ACC_WIDTH-1:0]  rd_re;
	logic signed [ACC_WIDTH-1:0]  rd_im;
	logic                         out_load;
	logic                         acc_clear;

	assign q_kind = cmd_kind_t'(q_data[KIND_W-1:0]);
	assign q_sec  = q_data[KIND_W+SEC_W-1:KIND_W];
	assign q_re   = q_data[KIND_W+SEC_W+VAL_W-1:KIND_W+SEC_W];
	assign q_im   = q_data[KIND_W+SEC_W+2*VAL_W-1:KIND_W+SEC_W+VAL_W];

	assign n_act = CNT_W'(active_count(cfg.sector_count, NUM_SECTORS));
	assign k_sec = SEC_W'(k_q);

	sfa_ram #(
		.WIDTH (2 * VAL_W),
		.DEPTH (NUM_SECTORS)
	) u_gain_ram (
		.clk   (clk),
		.we    (gain_we),
		.waddr (q_sec),
		.wdata ({q_im, q_re}),
		.raddr (rd_addr),
		.rdata (gain_rd)
	);

	sfa_ram #(
		.WIDTH (2 * ACC_WIDTH),
		.DEPTH (NUM_SECTORS)
	) u_acc_ram (
		.clk   (clk),
		.we    (acc_we),
		.waddr (cur_sec_q),
		.wdata (acc_wdata),
		.raddr (rd_addr),
		.rdata (acc_rd)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (q_valid) begin
					case (q_kind)
						CMD_RAY: begin
							if (cfg.gain_enable) begin
								state_d = B_MUL;
							end else if (cfg.magnitude_mode) begin
								state_d = B_SQ;
							end else begin
								state_d = B_ACC;
							end
						end
						CMD_READ: state_d = B_RO_RD;
						default:  state_d = B_IDLE;
					endcase
				end
			end
			B_MUL: begin
				if (step_q == 3'd4) begin
					state_d = B_RND;
				end
			end
			B_RND:    state_d = cfg.magnitude_mode ? B_SQ : B_ACC;
			B_SQ: begin
				if (step_q == 3'd2) begin
					state_d = B_SQRT;
				end
			end
			B_SQRT: begin
				if (bit_q[0]) begin
					state_d = B_ACC;
				end
			end
			B_ACC:    state_d = B_IDLE;
			B_RO_RD:  state_d = (k_q == n_act) ? B_IDLE : B_RO_OUT;
			B_RO_OUT: begin
				if (!out_vld_q || m_tready) begin
					state_d = B_RO_RD;
				end
			end
			default:  state_d = B_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		q_pop     = (state_q == B_IDLE) && q_valid;
		gain_we   = q_pop && (q_kind == CMD_GAIN);
		acc_we    = (state_q == B_ACC);
		out_load  = (state_q == B_RO_OUT) && (!out_vld_q || m_tready);
		acc_clear = (state_q == B_RO_RD) && (k_q == n_act);
		case (state_q)
			B_IDLE:   rd_addr = q_sec;
			B_RO_RD,
			B_RO_OUT: rd_addr = k_sec;
			default:  rd_addr = cur_sec_q;
		endcase
	end

	// Gain with unity default for entries never loaded
	assign gr = gain_vld_q[cur_sec_q] ? gain_rd[VAL_W-1:0] : GAIN_UNITY;
	assign gi = gain_vld_q[cur_sec_q] ? gain_rd[2*VAL_W-1:VAL_W] : '0;

	// Shared multiplier operand select
	always_comb begin
		mul_a = vr_q;
		mul_b = vr_q;
		if (state_q == B_MUL) begin
			case (step_q)
				3'd0: begin
					mul_a = gr;
					mul_b = vr_q;
				end
				3'd1: begin
					mul_a = gi;
					mul_b = vi_q;
				end
				3'd2: begin
					mul_a = gr;
					mul_b = vi_q;
				end
				default: begin
					mul_a = gi;
					mul_b = vr_q;
				end
			endcase
		end else if (state_q == B_SQ && step_q != 3'd0) begin
			mul_a = vi_q;
			mul_b = vi_q;
		end
	end

	assign trial = root_q + bit_q;

	// Accumulator update
	always_comb begin
		old_re    = acc_vld_q[cur_sec_q] ? acc_rd[ACC_WIDTH-1:0] : '0;
		old_im    = acc_vld_q[cur_sec_q] ? acc_rd[2*ACC_WIDTH-1:ACC_WIDTH] : '0;
		add_re    = cfg.magnitude_mode ? ACC_WIDTH'(root_q[ROOT_W-1:0]) : ACC_WIDTH'(vr_q);
		new_re    = sat_add(old_re, add_re);
		new_im    = cfg.magnitude_mode ? old_im : sat_add(old_im, ACC_WIDTH'(vi_q));
		acc_wdata = {new_im, new_re};
	end

	// Readout data, zero for sectors untouched since the last clear
	assign rd_re = acc_vld_q[k_sec] ? acc_rd[ACC_WIDTH-1:0] : '0;
	assign rd_im = acc_vld_q[k_sec] ? acc_rd[2*ACC_WIDTH-1:ACC_WIDTH] : '0;

	// Datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (q_pop) begin
			cur_sec_q <= q_sec;
			vr_q      <= q_re;
			vi_q      <= q_im;
		end
		// Complex gain product, one partial product per cycle
		if (state_q == B_MUL) begin
			case (step_q)
				3'd1:    re_acc_q <= CSUM_W'(prod_q);
				3'd2:    re_acc_q <= re_acc_q - CSUM_W'(prod_q);
				3'd3:    im_acc_q <= CSUM_W'(prod_q);
				3'd4:    im_acc_q <= im_acc_q + CSUM_W'(prod_q);
				default: ;
			endcase
		end
		if (state_q == B_RND) begin
			vr_q <= round_q15(re_acc_q);
			vi_q <= round_q15(im_acc_q);
		end
		// Sum of squares, then seed the square root
		if (state_q == B_SQ) begin
			if (step_q == 3'd1) begin
				sq_q <= prod_q;
			end else if (step_q == 3'd2) begin
				rem_q  <= sq_q + prod_q;
				root_q <= '0;
				bit_q  <= PROD_W'(1) << (PROD_W - 2);
			end
		end
		// One result bit per cycle
		if (state_q == B_SQRT) begin
			if (rem_q >= trial) begin
				rem_q  <= rem_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (out_load) begin
			out_idx_q  <= SIDX_W'(k_q);
			out_re_q   <= SUM_W'(rd_re);
			out_im_q   <= cfg.magnitude_mode ? '0 : SUM_W'(rd_im);
			out_last_q <= ((k_q + CNT_W'(1)) == n_act);
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			step_q     <= '0;
			k_q        <= '0;
			acc_vld_q  <= '0;
			gain_vld_q <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop || state_q == B_RND || state_d != state_q) begin
				step_q <= '0;
			end else if (state_q == B_MUL || state_q == B_SQ) begin
				step_q <= step_q + 3'd1;
			end
			if (q_pop) begin
				k_q <= '0;
			end else if (out_load) begin
				k_q <= k_q + CNT_W'(1);
			end
			if (gain_we) begin
				gain_vld_q[q_sec] <= 1'b1;
			end
			if (acc_clear) begin
				acc_vld_q <= '0;
			end else if (acc_we) begin
				acc_vld_q[cur_sec_q] <= 1'b1;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {out_im_q, out_re_q};
	assign m_tuser  = out_idx_q;
	assign m_tlast  = out_last_q;

endmodule

[src/sector_field_accumulator.sv]
// ---------------------------------------------------------------------------
// Sector field accumulator
// Bins rays by departure angle into sectors and accumulates field sums.
// ---------------------------------------------------------------------------
// Items are taken one at a time by the front end, which finds a ray's sector
// by testing one sector edge per cycle and queues the command in a two-entry
// queue. In coherent mode the back end adds a ray's value straight into its
// sector's sum; with gain enabled it first forms four partial products on one
// shared 16x16 multiplier plus rounding, in magnitude mode it forms two squares
// and a 16-step square root, and with both it does both. A gain load is written
// as its command is popped; a readout visits each active sector in turn and
// waits while the output register is stalled. Front and back work on different
// items at once, so the sustained rate is set by the slower of the two.
module sector_field_accumulator #(
	parameter int NUM_SECTORS = sfa_pkg::NUM_SECTORS_DEF,
	parameter int ACC_WIDTH   = sfa_pkg::ACC_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sfa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sfa_pkg::CFG_DATA_W-1:0]  cfg_data,
	// Input items
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// s_tdata: departure_angle[15:0], value_re[31:16], value_im[47:32],
	//          gain_sector[50:48], zero pad[55:51]
	input  logic [sfa_pkg::IN_TDATA_W-1:0]  s_tdata,
	// s_tuser: mode[1:0]
	input  logic [sfa_pkg::IN_TUSER_W-1:0]  s_tuser,
	// Result items
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// m_tdata: sum_re[39:0], sum_im[79:40]
	output logic [sfa_pkg::OUT_TDATA_W-1:0] m_tdata,
	// m_tuser: sector_index[2:0]
	output logic [sfa_pkg::OUT_TUSER_W-1:0] m_tuser,
	output logic                            m_tlast
);
	import sfa_pkg::*;

	localparam int CMD_W = CMD_FIXED_W + idx_w(NUM_SECTORS);

	cfg_t             cfg_q;
	logic             push;
	logic [CMD_W-1:0] push_data;
	logic             full;
	logic             pop;
	logic             pop_valid;
	logic [CMD_W-1:0] pop_data;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sector_count   <= COUNT_W'(8);
			cfg_q.sector_width   <= ANGLE_W'(8192);
			cfg_q.magnitude_mode <= 1'b0;
			cfg_q.gain_enable    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_SECTOR_COUNT: cfg_q.sector_count   <= cfg_data[COUNT_W-1:0];
				REG_SECTOR_WIDTH: cfg_q.sector_width   <= cfg_data[ANGLE_W-1:0];
				REG_MAG_MODE:     cfg_q.magnitude_mode <= cfg_data[0];
				REG_GAIN_EN:      cfg_q.gain_enable    <= cfg_data[0];
				default:          ;
			endcase
		end
	end

	sfa_front #(
		.NUM_SECTORS (NUM_SECTORS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	sfa_queue #(
		.WIDTH (CMD_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_data  (pop_data)
	);

	sfa_back #(
		.NUM_SECTORS (NUM_SECTORS),
		.ACC_WIDTH   (ACC_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (pop_valid),
		.q_data   (pop_data),
		.q_pop    (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

[src/sfa_checker.sv]
// ---------------------------------------------------------------------------
// Sector field accumulator port checker
// Watches the accumulator's ports and flags sequencing errors.
// ---------------------------------------------------------------------------
`include "sector_field_accumulator_assert.svh"

module sfa_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [sfa_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic [sfa_pkg::OUT_TUSER_W-1:0] m_tuser,
	input logic                            m_tlast
);
	import sfa_pkg::*;

	logic [SIDX_W-1:0] exp_idx_q;

	// Track the sector index expected on the next readout transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_idx_q <= '0;
		end else if (m_tvalid && m_tready) begin
			exp_idx_q <= m_tlast ? '0 : exp_idx_q + SIDX_W'(1);
		end
	end

	`SFA_ASSERT_ALWAYS(a_rst_quiet, clk, !arst_n |=> !m_tvalid, "result valid during reset")

	`SFA_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

	`SFA_ASSERT(a_idx_order, clk, arst_n, m_tvalid |-> m_tuser == exp_idx_q, "readout sector out of order")

	`SFA_ASSERT(a_in_busy, clk, arst_n, s_tvalid && s_tready |=> !s_tready, "input taken while item in front end")

endmodule

bind sector_field_accumulator sfa_checker u_sfa_checker (.*);

[test/tb_sector_field_accumulator.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sector field accumulator testbench
// Streams ray, gain-load and readout transfers into the accumulator under
// several sector setups, keeps a shadow of the sector sums and gain table,
// and checks every reported sector sum field by field as it leaves.
// ---------------------------------------------------------------------------
module tb_sector_field_accumulator;
	import sfa_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int LONG_HOLD     = 300;
	localparam int DRAIN_CYCLES  = 200;
	localparam int RANDOM_ITEMS  = 380;
	localparam int PHASE_COUNT   = 10;
	localparam longint SUM_MAX   = (longint'(1) << (SUM_W - 1)) - 1;
	localparam longint SUM_MIN   = -SUM_MAX - 1;

	typedef struct packed {
		logic [MODE_W-1:0]        mode;
		logic [ANGLE_W-1:0]       angle;
		logic signed [VAL_W-1:0]  re;
		logic signed [VAL_W-1:0]  im;
		logic [GSEC_W-1:0]        gsec;
	} ray_cmd_t;

	typedef struct packed {
		logic [SIDX_W-1:0]       sector;
		logic signed [SUM_W-1:0] sum_re;
		logic signed [SUM_W-1:0] sum_im;
		logic                    last;
	} sector_sum_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic [IN_TUSER_W-1:0]  s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [OUT_TUSER_W-1:0] m_tuser;
	logic                   m_tlast;

	// Shadow of the block's registers and tables
	logic [COUNT_W-1:0]      cnt_reg = 4'd8;
	logic [ANGLE_W-1:0]      width_reg = 16'd8192;
	bit                      mag_on;
	bit                      gain_on;
	logic signed [SUM_W-1:0] acc_re [NUM_SECTORS_DEF];
	logic signed [SUM_W-1:0] acc_im [NUM_SECTORS_DEF];
	logic signed [VAL_W-1:0] gain_re [NUM_SECTORS_DEF];
	logic signed [VAL_W-1:0] gain_im [NUM_SECTORS_DEF];

	ray_cmd_t    pending_items[$];
	sector_sum_t expected_sums[$];
	int          mismatches;

	// Sender and receiver state
	ray_cmd_t    tx_item;
	bit          tx_busy;
	int          tx_gap;
	bit          tx_no_idle;
	int          rx_wait;
	bit          rx_no_idle;
	bit          rx_long_hold;
	bit          rx_hold_taken;
	sector_sum_t rx_want;

	sector_field_accumulator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		// s_tdata: departure_angle, value_re, value_im, gain_sector, zero pad
		.s_tdata   (s_tdata),
		// s_tuser: mode
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		// m_tdata: sum_re, sum_im
		.m_tdata   (m_tdata),
		// m_tuser: sector_index
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Round a Q4.29 product to Q1.15, floor after adding half, then clip
	function automatic longint to_q15(longint p);
		longint r;
		r = (p + 8192) >>> 14;
		if (r > 32767) r = 32767;
		else if (r < -32768) r = -32768;
		return r;
	endfunction

	function automatic logic signed [SUM_W-1:0] sat_acc(logic signed [SUM_W-1:0] acc,
		longint v);
		longint s;
		s = longint'(acc) + v;
		if (s > SUM_MAX) s = SUM_MAX;
		else if (s < SUM_MIN) s = SUM_MIN;
		return s[SUM_W-1:0];
	endfunction

	function automatic int sectors_in_use();
		return (int'(cnt_reg) > NUM_SECTORS_DEF) ? NUM_SECTORS_DEF : int'(cnt_reg);
	endfunction

	// Bin, scale and accumulate one accepted transfer; queue readout sums
	function automatic void accumulate_item(ray_cmd_t it);
		int          n;
		int          sec;
		longint      vr, vi, gr, gi, pr, pim, rem, root, bitv;
		sector_sum_t rpt;
		n = sectors_in_use();
		case (it.mode)
		MODE_RAY: begin
			sec = -1;
			for (int k = 0; k < n; k++) begin
				if (longint'(it.angle) <= longint'(k + 1) * longint'(width_reg)) begin
					sec = k;
					break;
				end
			end
			if (sec >= 0) begin
				vr = longint'($signed(it.re));
				vi = longint'($signed(it.im));
				if (gain_on) begin
					gr = longint'($signed(gain_re[sec]));
					gi = longint'($signed(gain_im[sec]));
					pr = to_q15(gr * vr - gi * vi);
					pim = to_q15(gr * vi + gi * vr);
					vr = pr;
					vi = pim;
				end
				if (mag_on) begin
					// integer square root, one result bit per step
					rem = vr * vr + vi * vi;
					root = 0;
					bitv = longint'(1) << 32;
					while (bitv > rem) bitv = bitv >> 2;
					while (bitv != 0) begin
						if (rem >= root + bitv) begin
							rem = rem - (root + bitv);
							root = (root >> 1) + bitv;
						end else begin
							root = root >> 1;
						end
						bitv = bitv >> 2;
					end
					acc_re[sec] = sat_acc(acc_re[sec], root);
				end else begin
					acc_re[sec] = sat_acc(acc_re[sec], vr);
					acc_im[sec] = sat_acc(acc_im[sec], vi);
				end
			end
		end
		MODE_GAIN: begin
			if (int'(it.gsec) < NUM_SECTORS_DEF) begin
				gain_re[it.gsec] = it.re;
				gain_im[it.gsec] = it.im;
			end
		end
		MODE_READ: begin
			for (int k = 0; k < n; k++) begin
				rpt.sector = SIDX_W'(k);
				rpt.sum_re = acc_re[k];
				rpt.sum_im = mag_on ? '0 : acc_im[k];
				rpt.last = (k == n - 1);
				expected_sums.push_back(rpt);
			end
			for (int k = 0; k < NUM_SECTORS_DEF; k++) begin
				acc_re[k] = '0;
				acc_im[k] = '0;
			end
		end
		default: begin
		end
		endcase
	endfunction

	// Sender: offer queued items, drawing an idle gap before each one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			tx_busy = 1'b0;
			tx_gap = 0;
		end else begin
			// retire the transfer taken at this edge
			if (tx_busy && s_tready) begin
				accumulate_item(tx_item);
				tx_busy = 1'b0;
				tx_gap = tx_no_idle ? 0 : $urandom_range(0, 11);
			end
			// present the next item once the gap has run out
			if (!tx_busy) begin
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (pending_items.size() != 0) begin
					tx_item = pending_items.pop_front();
					tx_busy = 1'b1;
					s_tdata <= {5'b0, tx_item.gsec, tx_item.im, tx_item.re, tx_item.angle};
					s_tuser <= tx_item.mode;
				end
			end
			s_tvalid <= tx_busy;
		end
	end

	// Receiver: check each sum transfer, then stall for a drawn number of cycles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_wait = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_sums.size() == 0) begin
					$error("sum for sector %0d arrived with no readout pending", m_tuser);
					mismatches++;
				end else begin
					rx_want = expected_sums.pop_front();
					if (m_tuser !== rx_want.sector) begin
						$error("sector_index: expected %0d, got %0d", rx_want.sector, m_tuser);
						mismatches++;
					end
					if (m_tdata[SUM_W-1:0] !== rx_want.sum_re) begin
						$error("sum_re: expected %0d, got %0d", rx_want.sum_re,
							$signed(m_tdata[SUM_W-1:0]));
						mismatches++;
					end
					if (m_tdata[2*SUM_W-1:SUM_W] !== rx_want.sum_im) begin
						$error("sum_im: expected %0d, got %0d", rx_want.sum_im,
							$signed(m_tdata[2*SUM_W-1:SUM_W]));
						mismatches++;
					end
					if (m_tlast !== rx_want.last) begin
						$error("last: expected %0d, got %0d", rx_want.last, m_tlast);
						mismatches++;
					end
				end
				rx_wait = rx_no_idle ? 0 : $urandom_range(0, 11);
			end
			// hold off once for a long stretch so the block backs up
			if (rx_long_hold && !rx_hold_taken && m_tvalid) begin
				rx_wait = LONG_HOLD;
				rx_hold_taken = 1'b1;
			end
			if (rx_wait > 0) begin
				rx_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic void queue_item(logic [MODE_W-1:0] mode, int angle, int re, int im,
		int gsec);
		ray_cmd_t it;
		it.mode = mode;
		it.angle = angle[ANGLE_W-1:0];
		it.re = re[VAL_W-1:0];
		it.im = im[VAL_W-1:0];
		it.gsec = gsec[GSEC_W-1:0];
		pending_items.push_back(it);
	endfunction

	function automatic int rand_value();
		if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 32767 : -32768;
		return int'($signed(VAL_W'($urandom)));
	endfunction

	// Queue one random item; return 0 for items the block ignores
	function automatic bit queue_random();
		longint span;
		int     n;
		int     k;
		int     pick;
		int     angle;
		n = sectors_in_use();
		span = longint'(n) * longint'(width_reg);
		if (span > 65535) span = 65535;
		pick = $urandom_range(0, 99);
		if (pick < 72) begin
			case ($urandom_range(0, 7))
			0: angle = $urandom_range(0, 65535);
			1: begin
				// land on a sector edge or just past it
				k = $urandom_range(1, (n > 0) ? n : 1);
				angle = k * int'(width_reg) + $urandom_range(0, 1);
				if (angle > 65535) angle = 65535;
			end
			default: angle = $urandom_range(0, int'(span));
			endcase
			queue_item(MODE_RAY, angle, rand_value(), rand_value(), $urandom_range(0, 7));
		end else if (pick < 82) begin
			if ($urandom_range(0, 3) == 0)
				queue_item(MODE_GAIN, $urandom_range(0, 65535), int'(GAIN_UNITY), 0,
					$urandom_range(0, 7));
			else
				queue_item(MODE_GAIN, $urandom_range(0, 65535), rand_value(), rand_value(),
					$urandom_range(0, 7));
		end else if (pick < 95) begin
			queue_item(MODE_READ, $urandom_range(0, 65535), rand_value(), rand_value(),
				$urandom_range(0, 7));
		end else begin
			queue_item(MODE_UNUSED, $urandom_range(0, 65535), rand_value(), rand_value(),
				$urandom_range(0, 7));
			return 1'b0;
		end
		return 1'b1;
	endfunction

	// Write one register while the block is idle and mirror it
	task automatic write_reg(reg_idx_t idx, int val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
		REG_SECTOR_COUNT: cnt_reg = val[COUNT_W-1:0];
		REG_SECTOR_WIDTH: width_reg = val[ANGLE_W-1:0];
		REG_MAG_MODE:     mag_on = val[0];
		REG_GAIN_EN:      gain_on = val[0];
		default: begin
		end
		endcase
	endtask

	task automatic configure(int count, int width, int mag, int gen);
		write_reg(REG_SECTOR_COUNT, count);
		write_reg(REG_SECTOR_WIDTH, width);
		write_reg(REG_MAG_MODE, mag);
		write_reg(REG_GAIN_EN, gen);
	endtask

	// Wait until every item is sent and every sum is back, then let the back end finish
	task automatic wait_drained();
		while (pending_items.size() != 0 || tx_busy || s_tvalid || expected_sums.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int got;
		for (int k = 0; k < NUM_SECTORS_DEF; k++) begin
			acc_re[k] = '0;
			acc_im[k] = '0;
			gain_re[k] = GAIN_UNITY;
			gain_im[k] = '0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset setup: field extremes, sector edges, ignored mode, gain loads
		queue_item(MODE_RAY, 0, 32767, -32768, 0);
		queue_item(MODE_RAY, 65535, -32768, 32767, 7);
		queue_item(MODE_RAY, 8192, 1, -1, 0);
		queue_item(MODE_RAY, 8193, -1, 1, 0);
		queue_item(MODE_UNUSED, 65535, -1, -1, 7);
		queue_item(MODE_READ, 0, 0, 0, 0);
		queue_item(MODE_GAIN, 0, -32768, 32767, 0);
		queue_item(MODE_GAIN, 0, 32767, -32768, 3);
		queue_item(MODE_GAIN, 0, 0, 0, 7);
		queue_item(MODE_READ, 65535, -1, -1, 7);
		wait_drained();

		// Oversized count clamps, zero width lands only angle 0, gain and magnitude
		configure(15, 0, 1, 1);
		queue_item(MODE_RAY, 0, -32768, -32768, 0);
		queue_item(MODE_RAY, 1, 32767, 32767, 0);
		queue_item(MODE_RAY, 0, 32767, 32767, 0);
		queue_item(MODE_READ, 0, 0, 0, 0);
		wait_drained();

		// No active sector: rays dropped, readout reports nothing
		configure(0, 65535, 0, 1);
		queue_item(MODE_RAY, 100, 1000, 2000, 0);
		queue_item(MODE_READ, 0, 0, 0, 0);
		wait_drained();

		// Switch to magnitude mode with coherent sums still held
		configure(4, 100, 0, 0);
		queue_item(MODE_RAY, 50, 12345, -23456, 0);
		queue_item(MODE_RAY, 150, -32768, 32767, 0);
		queue_item(MODE_RAY, 400, 32767, 32767, 0);
		queue_item(MODE_RAY, 401, 7, 7, 0);
		wait_drained();
		write_reg(REG_MAG_MODE, 1);
		queue_item(MODE_READ, 0, 0, 0, 0);
		wait_drained();
		write_reg(REG_MAG_MODE, 0);
		queue_item(MODE_READ, 0, 0, 0, 0);
		wait_drained();

		// Random phases, each under its own sector setup
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			case (ph)
			0: configure(8, 8192, 0, 0);
			1: configure(1, 65535, 1, 1);
			2: configure(15, 3000, 0, 1);
			3: configure(5, 1, 1, 0);
			4: configure(0, 500, 0, 0);
			5: begin
				// stall the output while readouts and rays keep coming
				configure(8, 4000, 1, 1);
				rx_long_hold = 1'b1;
				tx_no_idle = 1'b1;
				repeat (3) queue_item(MODE_READ, 0, 0, 0, 0);
			end
			6: begin
				configure(3, 0, 0, 1);
				tx_no_idle = 1'b1;
				rx_no_idle = 1'b1;
			end
			default: configure($urandom_range(1, 8), $urandom_range(1, 16384),
				$urandom_range(0, 1), $urandom_range(0, 1));
			endcase
			got = 0;
			while (got < RANDOM_ITEMS / PHASE_COUNT) begin
				if (queue_random()) got++;
			end
			queue_item(MODE_READ, 0, 0, 0, 0);
			wait_drained();
			rx_long_hold = 1'b0;
			tx_no_idle = 1'b0;
			rx_no_idle = 1'b0;
		end

		if (mismatches == 0) begin
			$display("tb_sector_field_accumulator OK");
		end else begin
			$display("tb_sector_field_accumulator NOT OK");
		end
		$finish;
	end

	// Bound the run in case the block hangs
	initial begin
		#5_000_000;
		$display("tb_sector_field_accumulator NOT OK");
		$finish;
	end

endmodule
